/* hdl/stepper_step_dir_pulse_generator_core_assert.svh */
// Assertion macros for the step/direction pulse generator checker.
// Needs signals named clk and rst_n in the scope of use.
`ifndef STEPPER_STEP_DIR_PULSE_GENERATOR_CORE_ASSERT_SVH
`define STEPPER_STEP_DIR_PULSE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is held
`define STEPDIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held
`define STEPDIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/stepdir_pkg.sv */
// Shared types and constants for the step/direction pulse generator.
// No dependencies.
package stepdir_pkg;

  // Default widths for the top level parameters
  localparam int DELAY_WIDTH_DEF    = 24;
  localparam int POSITION_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH        = 32;

  // Timing limits
  localparam logic [31:0] MIN_HALF_PERIOD   = 32'd2;
  localparam logic [31:0] RESET_HALF_PERIOD = 32'd5000;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_MOVE       = 2'd1,
    OP_STOP       = 2'd2,
    OP_SET_ENABLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_CONTROL_MODE   = 3'd0,
    REG_MICROSTEP_CODE = 3'd1,
    REG_HOLD_AFTER     = 3'd2,
    REG_DEFAULT_HALF   = 3'd3,
    REG_ENABLE_POL     = 3'd4
  } cfg_reg_t;

endpackage

/* hdl/stepper_step_dir_pulse_generator_core.sv */
// Step/direction pulse generator, one motor channel.
// Depends on stepdir_pkg.
//
// Channel  | Ports                       | Direction
// in       | in_valid / in_ready + item  | command or tick into the block
// out      | out_valid / out_ready + res | one result per item, state after it
// cfg      | cfg_we, cfg_index, cfg_wdata| register write, no handshake
//
// Each item goes through an input register and then a result register; one item
// per cycle is sustained while the result side keeps out_ready high.
// The state update for an item is a single pass of parallel adds and compares.
// Synchronous active-low reset clears state and restores register defaults.
// A stalled result stops the input register from draining; the input register
// still takes one more item, so ready falls only with both registers full.
module stepper_step_dir_pulse_generator_core
  import stepdir_pkg::*;
#(
  parameter int DELAY_WIDTH    = DELAY_WIDTH_DEF,
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic                             in_direction,
  input  logic [COUNT_WIDTH-1:0]           in_step_count,
  input  logic [DELAY_WIDTH-1:0]           in_step_delay,
  input  logic                             in_keep_enabled,
  input  logic                             in_enable_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic                             out_busy_res,
  output logic                             out_step_pin,
  output logic                             out_dir_pin,
  output logic                             out_enable_pin,
  output logic [2:0]                       out_mode_pins,
  output logic [COUNT_WIDTH-1:0]           out_steps_done,
  output logic signed [POSITION_WIDTH-1:0] out_position,
  // configuration
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [DELAY_WIDTH-1:0]           cfg_wdata
);

  // Configuration registers
  logic                   ctrl_mode_r;
  logic [2:0]             microstep_r;
  logic                   hold_after_r;
  logic [DELAY_WIDTH-1:0] default_half_r;
  logic                   en_pol_high_r;

  // Input register
  logic                   in_valid_r;
  op_t                    in_op_r;
  logic                   in_dir_r;
  logic [COUNT_WIDTH-1:0] in_count_r;
  logic [DELAY_WIDTH-1:0] in_delay_r;
  logic                   in_keep_r;
  logic                   in_en_val_r;

  // Channel state
  logic                      moving_r,   moving_nxt;
  logic                      motor_en_r, motor_en_nxt;
  logic                      dir_r,      dir_nxt;
  logic                      stop_r,     stop_nxt;
  logic                      keep_r,     keep_nxt;
  logic [DELAY_WIDTH-1:0]    half_r,     half_nxt;
  logic [DELAY_WIDTH-1:0]    phase_r,    phase_nxt;
  logic                      pulse_r,    pulse_nxt;
  logic [COUNT_WIDTH-1:0]    target_r,   target_nxt;
  logic [COUNT_WIDTH-1:0]    done_r,     done_nxt;
  logic [POSITION_WIDTH-1:0] pos_r,      pos_nxt;
  status_t                   status_nxt;

  // Result register
  logic                      out_valid_r;
  status_t                   res_status_r;
  logic                      res_busy_r;
  logic                      res_step_r;
  logic                      res_dir_r;
  logic                      res_en_r;
  logic [2:0]                res_mode_r;
  logic [COUNT_WIDTH-1:0]    res_done_r;
  logic [POSITION_WIDTH-1:0] res_pos_r;

  logic                      advance;
  logic                      process;
  logic [DELAY_WIDTH-1:0]    phase_inc;
  logic [COUNT_WIDTH-1:0]    done_inc;
  logic [DELAY_WIDTH-1:0]    eff_delay;

  // Handshake: result register drains, input register refills behind it
  assign advance  = !out_valid_r || out_ready;
  assign process  = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_mode_r    <= 1'b0;
      microstep_r    <= 3'd0;
      hold_after_r   <= 1'b0;
      default_half_r <= DELAY_WIDTH'(RESET_HALF_PERIOD);
      en_pol_high_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CONTROL_MODE:   ctrl_mode_r    <= cfg_wdata[0];
        REG_MICROSTEP_CODE: microstep_r    <= cfg_wdata[2:0];
        REG_HOLD_AFTER:     hold_after_r   <= cfg_wdata[0];
        REG_DEFAULT_HALF:   default_half_r <= cfg_wdata;
        REG_ENABLE_POL:     en_pol_high_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op_r     <= op_t'(in_operation);
      in_dir_r    <= in_direction;
      in_count_r  <= in_step_count;
      in_delay_r  <= in_step_delay;
      in_keep_r   <= in_keep_enabled;
      in_en_val_r <= in_enable_value;
    end
  end

  assign phase_inc = phase_r + DELAY_WIDTH'(1);
  assign done_inc  = done_r + COUNT_WIDTH'(1);
  assign eff_delay = (in_delay_r == '0) ? default_half_r : in_delay_r;

  // State update for one item
  always_comb begin
    moving_nxt   = moving_r;
    motor_en_nxt = motor_en_r;
    dir_nxt      = dir_r;
    stop_nxt     = stop_r;
    keep_nxt     = keep_r;
    half_nxt     = half_r;
    phase_nxt    = phase_r;
    pulse_nxt    = pulse_r;
    target_nxt   = target_r;
    done_nxt     = done_r;
    pos_nxt      = pos_r;
    status_nxt   = ST_OK;
    case (in_op_r)
      OP_TICK: begin
        if (moving_r) begin
          if (phase_inc < half_r) begin
            phase_nxt = phase_inc;
          end else begin
            phase_nxt = '0;
            if (pulse_r) begin
              pulse_nxt = 1'b0;
            end else begin
              // low half over: one step finished
              done_nxt = done_inc;
              pos_nxt  = dir_r ? pos_r - POSITION_WIDTH'(1) : pos_r + POSITION_WIDTH'(1);
              if (done_inc >= target_r || stop_r) begin
                moving_nxt = 1'b0;
                pulse_nxt  = 1'b0;
                stop_nxt   = 1'b0;
                if (!keep_r || stop_r) begin
                  motor_en_nxt = 1'b0;
                end
              end else begin
                pulse_nxt = 1'b1;
              end
            end
          end
        end
      end
      OP_MOVE: begin
        if (in_count_r == '0) begin
          status_nxt = ST_INVALID;
        end else if (moving_r) begin
          status_nxt = ST_BUSY;
        end else if ({{(32-DELAY_WIDTH){1'b0}}, eff_delay} < MIN_HALF_PERIOD) begin
          status_nxt = ST_INVALID;
        end else begin
          moving_nxt   = 1'b1;
          stop_nxt     = 1'b0;
          done_nxt     = '0;
          target_nxt   = in_count_r;
          dir_nxt      = in_dir_r;
          keep_nxt     = in_keep_r || hold_after_r;
          half_nxt     = eff_delay;
          phase_nxt    = '0;
          pulse_nxt    = 1'b1;
          motor_en_nxt = 1'b1;
        end
      end
      OP_STOP: begin
        if (moving_r) begin
          stop_nxt = 1'b1;
        end else begin
          motor_en_nxt = 1'b0;
        end
      end
      OP_SET_ENABLE: begin
        if (moving_r) begin
          status_nxt = ST_BUSY;
        end else begin
          motor_en_nxt = in_en_val_r;
        end
      end
      default: ;
    endcase
  end

  // Channel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r   <= 1'b0;
      motor_en_r <= 1'b0;
      dir_r      <= 1'b0;
      stop_r     <= 1'b0;
      keep_r     <= 1'b0;
      half_r     <= '0;
      phase_r    <= '0;
      pulse_r    <= 1'b0;
      target_r   <= '0;
      done_r     <= '0;
      pos_r      <= '0;
    end else if (process) begin
      moving_r   <= moving_nxt;
      motor_en_r <= motor_en_nxt;
      dir_r      <= dir_nxt;
      stop_r     <= stop_nxt;
      keep_r     <= keep_nxt;
      half_r     <= half_nxt;
      phase_r    <= phase_nxt;
      pulse_r    <= pulse_nxt;
      target_r   <= target_nxt;
      done_r     <= done_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res_status_r <= status_nxt;
      res_busy_r   <= moving_nxt;
      res_step_r   <= moving_nxt && pulse_nxt;
      res_dir_r    <= dir_nxt;
      res_en_r     <= en_pol_high_r ? motor_en_nxt : !motor_en_nxt;
      res_mode_r   <= ctrl_mode_r ? microstep_r : 3'd0;
      res_done_r   <= done_nxt;
      res_pos_r    <= pos_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = res_status_r;
  assign out_busy_res   = res_busy_r;
  assign out_step_pin   = res_step_r;
  assign out_dir_pin    = res_dir_r;
  assign out_enable_pin = res_en_r;
  assign out_mode_pins  = res_mode_r;
  assign out_steps_done = res_done_r;
  assign out_position   = $signed(res_pos_r);

endmodule

/* hdl/stepdir_checker.sv */
// Port-level checks for the step/direction pulse generator, bound to the top.
// Depends on stepdir_pkg and stepper_step_dir_pulse_generator_core_assert.svh.
`include "stepper_step_dir_pulse_generator_core_assert.svh"

module stepdir_checker
  import stepdir_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       out_status,
  input logic                             out_busy_res,
  input logic                             out_step_pin,
  input logic [COUNT_WIDTH-1:0]           out_steps_done,
  input logic signed [POSITION_WIDTH-1:0] out_position
);

  // A held result keeps its payload until the transfer
  `STEPDIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_steps_done) && $stable(out_position), "result changed while stalled")

  // Input back-pressure only comes from a stalled result
  `STEPDIR_ASSERT_NOW(a_ready_cause, !in_ready, out_valid && !out_ready, "input stalled without a stalled result")

  // No step pulse outside a move
  `STEPDIR_ASSERT_NOW(a_step_idle, out_valid && !out_busy_res, !out_step_pin, "step pin high while idle")

  // A busy refusal leaves the move running
  `STEPDIR_ASSERT_NOW(a_busy_moving, out_valid && out_status == ST_BUSY, out_busy_res, "busy status while idle")

endmodule

bind stepper_step_dir_pulse_generator_core stepdir_checker #(
  .POSITION_WIDTH(POSITION_WIDTH)
) u_stepdir_checker (.*);
